// ----- rtl/ipv4_header_builder_macros.svh -----
// Assertion macros shared by the IPv4 header builder RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IPV4_HEADER_BUILDER_MACROS_SVH
`define IPV4_HEADER_BUILDER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define IPV4HB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the following cycle.
`define IPV4HB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ipv4hb_pkg.sv -----
// Types and constants of the IPv4 header builder.
// No dependencies; imported by ipv4hb_hdr_calc, ipv4_header_builder and the testbench.
`timescale 1ns / 1ps

package ipv4hb_pkg;

    localparam int unsigned HDR_WORDS   = 5;
    localparam int unsigned LEN_W       = 17;
    localparam logic [LEN_W-1:0] HDR_BYTES = 17'd20;
    localparam logic [LEN_W-1:0] MTU_BYTES = 17'd1500;
    localparam logic [31:0] BCAST_ADDR  = 32'hFFFF_FFFF;
    localparam logic [7:0]  VER_IHL     = 8'h45;
    localparam logic [7:0]  TTL_DEFAULT = 8'd64;
    localparam logic [15:0] IDENT_RESET = 16'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_LOCAL_ADDR   = 2'd0;
    localparam logic [1:0] CFG_SUBNET_MASK  = 2'd1;
    localparam logic [1:0] CFG_GATEWAY_ADDR = 2'd2;

    // Built header and routing decisions for one request
    typedef struct packed {
        logic [HDR_WORDS-1:0][31:0] words;
        logic                       bcast;
        logic [31:0]                hop;
        logic                       reject;
    } hdr_t;

endpackage

// ----- rtl/ipv4_header_builder.sv -----
// IPv4 header builder: one send request in, five header word beats out
// (or a single reject beat when the total length exceeds 1500 bytes).
// Request beats pass an input register, are built in one pass into a header
// register and leave through an output register, one word a cycle unless the
// output stalls. The next request is taken while the current header drains,
// so five-word headers stream back to back. Identification starts at 1 after
// reset and advances on each non-rejected request. Configuration is written
// through cfg_valid/cfg_ready, always ready. Depends on ipv4hb_pkg,
// ipv4hb_hdr_calc and the macro header.
`timescale 1ns / 1ps
`include "ipv4_header_builder_macros.svh"

module ipv4_header_builder
    import ipv4hb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Request channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] dest_addr,
    input  logic [7:0]  proto,
    input  logic [15:0] data_len,
    // Header word channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] header_word,
    output logic [2:0]  word_index,
    output logic        last,
    output logic        status,
    output logic        is_broadcast,
    output logic [31:0] hop_addr
);

    logic [31:0] local_addr_reg;
    logic [31:0] subnet_mask_reg;
    logic [31:0] gateway_addr_reg;
    logic [15:0] ident_reg;

    logic        hold_valid_reg;
    logic [31:0] hold_dest_reg;
    logic [7:0]  hold_proto_reg;
    logic [15:0] hold_len_reg;

    hdr_t        calc;
    hdr_t        hdr_reg;
    logic        hdr_valid_reg;
    logic [2:0]  idx_reg;

    logic        out_valid_reg;
    logic [31:0] header_word_reg;
    logic [2:0]  word_index_reg;
    logic        last_reg;
    logic        status_reg;
    logic        bcast_reg;
    logic [31:0] hop_reg;

    logic        in_beat;
    logic        out_load;
    logic        last_word;
    logic        load_hdr;
    logic [31:0] sel_word;

    // Configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_addr_reg   <= '0;
            subnet_mask_reg  <= '0;
            gateway_addr_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_LOCAL_ADDR:   local_addr_reg   <= cfg_data;
                CFG_SUBNET_MASK:  subnet_mask_reg  <= cfg_data;
                CFG_GATEWAY_ADDR: gateway_addr_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Handshake decisions
    assign last_word = hdr_reg.reject || (idx_reg == 3'(HDR_WORDS - 1));
    assign out_load  = hdr_valid_reg && (!out_valid_reg || !out_stall);
    assign load_hdr  = hold_valid_reg && (!hdr_valid_reg || (out_load && last_word));
    assign in_stall  = hold_valid_reg && !load_hdr;
    assign in_beat   = in_valid && !in_stall;

    // Input register: capture request beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (in_beat)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (load_hdr)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            hold_dest_reg  <= dest_addr;
            hold_proto_reg <= proto;
            hold_len_reg   <= data_len;
        end
    end

    ipv4hb_hdr_calc u_calc (
        .dest_addr    (hold_dest_reg),
        .proto        (hold_proto_reg),
        .data_len     (hold_len_reg),
        .local_addr   (local_addr_reg),
        .subnet_mask  (subnet_mask_reg),
        .gateway_addr (gateway_addr_reg),
        .ident        (ident_reg),
        .hdr          (calc)
    );

    // Header register and word counter; advance identification on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_valid_reg <= 1'b0;
            idx_reg       <= '0;
            ident_reg     <= IDENT_RESET;
        end
        else
        begin
            if (load_hdr)
            begin
                hdr_valid_reg <= 1'b1;
                idx_reg       <= '0;
                if (!calc.reject)
                begin
                    ident_reg <= ident_reg + 16'd1;
                end
            end
            else if (out_load)
            begin
                if (last_word)
                begin
                    hdr_valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_hdr)
        begin
            hdr_reg <= calc;
        end
    end

    // Select the word to emit
    always_comb
    begin
        case (idx_reg)
            3'd0:    sel_word = hdr_reg.words[0];
            3'd1:    sel_word = hdr_reg.words[1];
            3'd2:    sel_word = hdr_reg.words[2];
            3'd3:    sel_word = hdr_reg.words[3];
            default: sel_word = hdr_reg.words[4];
        endcase
    end

    // Output register: hold beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            header_word_reg <= hdr_reg.reject ? 32'h0 : sel_word;
            word_index_reg  <= idx_reg;
            last_reg        <= last_word;
            status_reg      <= hdr_reg.reject;
            bcast_reg       <= hdr_reg.bcast;
            hop_reg         <= hdr_reg.hop;
        end
    end

    assign out_valid    = out_valid_reg;
    assign header_word  = header_word_reg;
    assign word_index   = word_index_reg;
    assign last         = last_reg;
    assign status       = status_reg;
    assign is_broadcast = bcast_reg;
    assign hop_addr     = hop_reg;

    // Assertions
    `IPV4HB_ASSERT_SAME(a_reject_beat, clk, rst_n, out_valid && status,
        (header_word == 32'h0) && (word_index == 3'd0) && last,
        "reject beat must be a single zero word")
    `IPV4HB_ASSERT_SAME(a_last_index, clk, rst_n, out_valid && last && !status,
        word_index == 3'(HDR_WORDS - 1), "header ends on a word other than the fifth")
    `IPV4HB_ASSERT_NEXT(a_words_contiguous, clk, rst_n, out_valid && !out_stall && !last,
        out_valid && (word_index == 3'($past(word_index) + 3'd1)),
        "header words not emitted back to back in order")
    `IPV4HB_ASSERT_NEXT(a_ident_step, clk, rst_n, load_hdr && !calc.reject,
        ident_reg == 16'($past(ident_reg) + 16'd1),
        "identification did not advance on accepted header")

endmodule

// ----- rtl/ipv4hb_hdr_calc.sv -----
// Header word and checksum computation for one send request.
// Depends on ipv4hb_pkg.
`timescale 1ns / 1ps

module ipv4hb_hdr_calc
    import ipv4hb_pkg::*;
(
    input  logic [31:0] dest_addr,
    input  logic [7:0]  proto,
    input  logic [15:0] data_len,
    input  logic [31:0] local_addr,
    input  logic [31:0] subnet_mask,
    input  logic [31:0] gateway_addr,
    input  logic [15:0] ident,
    output hdr_t        hdr
);

    logic             bcast;
    logic             on_link;
    logic [LEN_W-1:0] total;
    logic [15:0]      w0_lo;
    logic [15:0]      w2_hi;
    logic [19:0]      acc;
    logic [16:0]      fold1;
    logic [16:0]      fold2;
    logic [15:0]      csum;

    // Route decision: broadcast and on-link go direct
    assign bcast   = (dest_addr == BCAST_ADDR);
    assign on_link = bcast || ((dest_addr & subnet_mask) == (local_addr & subnet_mask));

    // Total length at full width so oversize never wraps
    assign total = {1'b0, data_len} + HDR_BYTES;
    assign w0_lo = total[15:0];
    assign w2_hi = {TTL_DEFAULT, proto};

    // Ones'-complement sum of the header halves, checksum field as zero
    assign acc = 20'({VER_IHL, 8'h00}) + 20'(w0_lo) + 20'(ident)
               + 20'(w2_hi) + 20'(local_addr[31:16]) + 20'(local_addr[15:0])
               + 20'(dest_addr[31:16]) + 20'(dest_addr[15:0]);
    assign fold1 = 17'(acc[15:0]) + 17'(acc[19:16]);
    assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
    assign csum  = ~fold2[15:0];

    always_comb
    begin
        hdr.words[0] = {VER_IHL, 8'h00, w0_lo};
        hdr.words[1] = {ident, 16'h0000};
        hdr.words[2] = {w2_hi, csum};
        hdr.words[3] = local_addr;
        hdr.words[4] = dest_addr;
        hdr.bcast    = bcast;
        hdr.hop      = on_link ? dest_addr : gateway_addr;
        hdr.reject   = (total > MTU_BYTES);
    end

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for ipv4_header_builder: request beats in, header word beats out.
// Depends on ipv4hb_pkg and the ipv4_header_builder RTL; expected beats are predicted in-line.
`timescale 1ns / 1ps

module testbench;
    import ipv4hb_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES   = 10;
    localparam int unsigned MAX_REPORTS    = 10;

    // Status codes of a header beat
    localparam logic ST_ACCEPT = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    typedef struct packed {
        logic [31:0] header_word;
        logic [2:0]  word_index;
        logic        last;
        logic        status;
        logic        is_broadcast;
        logic [31:0] hop_addr;
    } hdr_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = CFG_LOCAL_ADDR;
    logic [31:0] cfg_data    = '0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    logic [31:0] dest_addr   = '0;
    logic [7:0]  proto       = '0;
    logic [15:0] data_len    = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    logic [31:0] header_word;
    logic [2:0]  word_index;
    logic        last;
    logic        status;
    logic        is_broadcast;
    logic [31:0] hop_addr;

    // Predictor state: routing registers and identification of the next header
    logic [31:0] own_addr   = '0;
    logic [31:0] net_mask   = '0;
    logic [31:0] gw_addr    = '0;
    logic [15:0] next_ident = IDENT_RESET;

    hdr_beat_t   header_beats_due[$];

    int unsigned send_idle_pct   = 13;
    int unsigned recv_stall_pct  = 50;
    int unsigned quiet_cycles    = 0;
    int unsigned requests_sent   = 0;
    int unsigned requests_reject = 0;
    int unsigned beats_checked   = 0;
    int unsigned mismatches      = 0;
    int unsigned unexpected      = 0;
    int unsigned reported        = 0;
    int unsigned settings_loaded = 0;
    int unsigned ident_wraps     = 0;

    ipv4_header_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .dest_addr    (dest_addr),
        .proto        (proto),
        .data_len     (data_len),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .header_word  (header_word),
        .word_index   (word_index),
        .last         (last),
        .status       (status),
        .is_broadcast (is_broadcast),
        .hop_addr     (hop_addr)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Work out the header beats that one accepted request must produce
    function automatic void predict_header(input logic [31:0] dst, input logic [7:0] prot,
                                           input logic [15:0] len);
        logic        bcast;
        logic        on_link;
        logic [31:0] hop;
        logic [16:0] total;
        logic [31:0] words [5];
        logic [31:0] acc;
        hdr_beat_t   beat;
        bcast   = (dst == BCAST_ADDR);
        on_link = bcast || ((dst & net_mask) == (own_addr & net_mask));
        hop     = on_link ? dst : gw_addr;
        total   = {1'b0, len} + HDR_BYTES;
        requests_sent++;
        if (total > MTU_BYTES)
        begin
            requests_reject++;
            beat = {32'h0, 3'd0, 1'b1, ST_REJECT, bcast, hop};
            header_beats_due.push_back(beat);
            return;
        end
        words[0] = {VER_IHL, 8'h00, total[15:0]};
        words[1] = {next_ident, 16'h0000};
        words[2] = {TTL_DEFAULT, prot, 16'h0000};
        words[3] = own_addr;
        words[4] = dst;
        // Ones'-complement sum of the ten halves, checksum field taken as zero
        acc = '0;
        for (int i = 0; i < 5; i++)
            acc = acc + words[i][31:16] + words[i][15:0];
        acc = acc[15:0] + acc[31:16];
        acc = acc[15:0] + acc[31:16];
        words[2][15:0] = ~acc[15:0];
        if (next_ident == 16'hFFFF)
            ident_wraps++;
        next_ident = next_ident + 16'd1;
        for (int i = 0; i < 5; i++)
        begin
            beat = {words[i], 3'(i), (i == 4), ST_ACCEPT, bcast, hop};
            header_beats_due.push_back(beat);
        end
    endfunction

    // Offer one request beat, hold it until taken, then predict its header
    task automatic send_request(input logic [31:0] dst, input logic [7:0] prot,
                                input logic [15:0] len);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        dest_addr <= dst;
        proto     <= prot;
        data_len  <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_header(dst, prot, len);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (index)
            CFG_LOCAL_ADDR:   own_addr = value;
            CFG_SUBNET_MASK:  net_mask = value;
            CFG_GATEWAY_ADDR: gw_addr  = value;
            default: ;
        endcase
    endtask

    // Write all three routing registers back to back, then release the channel
    task automatic load_routing(input logic [31:0] addr, input logic [31:0] mask,
                                input logic [31:0] gw);
        write_register(CFG_LOCAL_ADDR, addr);
        write_register(CFG_SUBNET_MASK, mask);
        write_register(CFG_GATEWAY_ADDR, gw);
        cfg_valid <= 1'b0;
        settings_loaded++;
        @(posedge clk);
    endtask

    task automatic load_random_routing();
        int unsigned prefix;
        logic [31:0] mask;
        prefix = $urandom_range(32);
        mask   = (prefix == 0) ? 32'h0 : (~32'h0 << (32 - prefix));
        if ($urandom_range(3) == 0)
            mask = $urandom;
        load_routing($urandom, mask, $urandom);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (header_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Favor on-link and broadcast destinations so both routing paths stay busy
    function automatic logic [31:0] pick_dest();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45)
            return (own_addr & net_mask) | ($urandom & ~net_mask);
        else if (sel < 55)
            return BCAST_ADDR;
        else if (sel < 60)
            return own_addr;
        return $urandom;
    endfunction

    // Mostly legal lengths, some near the MTU edge, some anywhere in range
    function automatic logic [15:0] pick_len();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return 16'($urandom_range(1480));
        else if (sel < 85)
            return 16'($urandom_range(1490, 1470));
        return 16'($urandom_range(65535));
    endfunction

    task automatic test_reset_defaults();
        send_request(32'h0000_0000, 8'h00, 16'd0);
        send_request(BCAST_ADDR, 8'hFF, 16'd1480);
    endtask

    task automatic test_routing_and_mtu();
        settle();
        load_routing(32'hC0A8_010A, 32'hFFFF_FF00, 32'hC0A8_0101);
        send_request(32'hC0A8_014D, 8'd17, 16'd100);
        // exactly at the MTU, then one byte over
        send_request(32'h0A00_0001, 8'd6, 16'd1480);
        send_request(32'h0A00_0001, 8'd6, 16'd1481);
        // totals that would look small if cut to 16 bits
        send_request(32'hC0A8_0177, 8'd1, 16'd65535);
        send_request(32'hC0A8_0177, 8'd1, 16'd65516);
        send_request(BCAST_ADDR, 8'd17, 16'd0);
        send_request(BCAST_ADDR, 8'd17, 16'd2000);
        send_request(32'hC0A8_010A, 8'd255, 16'd0);
        settle();
        load_routing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(BCAST_ADDR, 8'h00, 16'd20);
        send_request(32'hFFFF_FFFE, 8'hAA, 16'h5555);
        send_request(32'h0000_0000, 8'h55, 16'd1000);
        settle();
        load_routing(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'h8000_0001, 8'd6, 16'd1479);
        send_request(32'h7FFF_FFFF, 8'd6, 16'hAAAA);
        settle();
        load_routing(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h1234_5678, 8'd50, 16'd64);
        send_request(32'h0000_0000, 8'd50, 16'd64);
    endtask

    // Three routing settings per call, random requests under each
    task automatic test_random_traffic(input int unsigned per_setting);
        for (int s = 0; s < 3; s++)
        begin
            settle();
            load_random_routing();
            repeat (per_setting)
                send_request(pick_dest(), 8'($urandom), pick_len());
        end
    endtask

    // Drive stall and check every header beat taken
    always @(posedge clk)
    begin : check_beats
        hdr_beat_t got;
        hdr_beat_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {header_word, word_index, last, status, is_broadcast, hop_addr};
                beats_checked++;
                if (header_beats_due.size() == 0)
                begin
                    unexpected++;
                    if (reported < MAX_REPORTS)
                    begin
                        reported++;
                        $display("unexpected beat: word=%08h idx=%0d last=%0b status=%0b",
                                 got.header_word, got.word_index, got.last, got.status);
                    end
                end
                else
                begin
                    want = header_beats_due.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (reported < MAX_REPORTS)
                        begin
                            reported++;
                            $display({"mismatch expected: word=%08h idx=%0d last=%0b",
                                      " st=%0b bc=%0b hop=%08h"},
                                     want.header_word, want.word_index, want.last, want.status,
                                     want.is_broadcast, want.hop_addr);
                            $display({"         actual:   word=%08h idx=%0d last=%0b",
                                      " st=%0b bc=%0b hop=%08h"},
                                     got.header_word, got.word_index, got.last, got.status,
                                     got.is_broadcast, got.hop_addr);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Count cycles in which no beat moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("ipv4_header_builder test failed");
        $finish;
    end

    initial
    begin
        int unsigned leftover;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_routing_and_mtu();
        test_random_traffic(57);
        send_idle_pct  = 50;
        recv_stall_pct = 13;
        test_random_traffic(57);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_traffic(57);
        settle();

        leftover = header_beats_due.size();
        $display("%0d requests (%0d over the MTU), %0d header beats checked, %0d mismatches",
                 requests_sent, requests_reject, beats_checked, mismatches);
        $display("%0d routing settings, identification wrapped %0d times, %0d beats missing",
                 settings_loaded, ident_wraps, leftover);
        if (mismatches == 0 && unexpected == 0 && leftover == 0)
            $display("ipv4_header_builder test passed");
        else
            $display("ipv4_header_builder test failed");
        $finish;
    end

endmodule
